### hw/rtl/swqz_pkg.sv
// ----------------------------------------------------------------------------
// swqz_pkg
// Shared types and constants of the sliding window quantile zoner.
// ----------------------------------------------------------------------------
`default_nettype none

package swqz_pkg;

  localparam int unsigned PRICE_W   = 20;  // price field width
  localparam int unsigned CNT_W     = 11;  // histogram bin counter width
  localparam int unsigned PCT_W     = 7;   // percent register width
  localparam int unsigned WL_W      = 11;  // window length register width
  localparam int unsigned MIN_W     = 6;   // minute field width
  localparam int unsigned ZONE_W    = 3;   // zone code width
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_LVL   = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH = 3'd0,
    CFG_PRICE_BASE    = 3'd1,
    CFG_FLOOR_PCT     = 3'd2,
    CFG_LOW_PCT       = 3'd3,
    CFG_MID_PCT       = 3'd4,
    CFG_HIGH_PCT      = 3'd5,
    CFG_CEILING_PCT   = 3'd6
  } cfg_idx_e;

  typedef enum logic [ZONE_W-1:0] {
    ZONE_UNKNOWN  = 3'd0,
    ZONE_EXTREME  = 3'd1,
    ZONE_VERY_LOW = 3'd2,
    ZONE_LOW      = 3'd3,
    ZONE_NORMAL   = 3'd4,
    ZONE_HIGH     = 3'd5
  } zone_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_FILL,
    ST_FILL_WR,
    ST_EVICT_RD,
    ST_EVICT_WR,
    ST_INC_RD,
    ST_INC_WR,
    ST_SCAN,
    ST_RESP
  } state_e;

  // level update from the scan unit
  typedef struct packed {
    logic               we;
    logic [2:0]         idx;
    logic [PRICE_W-1:0] value;
  } lvl_wr_t;

  // scan unit completion status
  typedef struct packed {
    logic done;
    logic err;
  } scan_stat_t;

endpackage

`default_nettype wire

### hw/rtl/swqz_ram.sv
// ----------------------------------------------------------------------------
// swqz_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swqz_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/swqz_scan.sv
// ----------------------------------------------------------------------------
// swqz_scan
// Streams the histogram from bin zero upward and finds the five zone levels.
// ----------------------------------------------------------------------------
`default_nettype none

module swqz_scan #(
  parameter int unsigned PRICE_BINS = 1024,
  parameter int unsigned LEN_W      = 11
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [LEN_W-1:0]                 len_i,
  input  wire logic [swqz_pkg::PCT_W-1:0]       pct_i [swqz_pkg::NUM_LVL],
  input  wire logic [swqz_pkg::PRICE_W-1:0]     base_i,
  output logic      [$clog2(PRICE_BINS)-1:0]    raddr_o,
  input  wire logic [swqz_pkg::CNT_W-1:0]       rdata_i,
  output swqz_pkg::lvl_wr_t                     lvl_wr_o,
  output swqz_pkg::scan_stat_t                  stat_o
);
  import swqz_pkg::*;

  localparam int unsigned BIN_W  = $clog2(PRICE_BINS);
  localparam int unsigned NEED_W = PCT_W + LEN_W;
  localparam int unsigned SUM_W  = CNT_W + PCT_W + BIN_W + 1;
  localparam int unsigned ACC_W  = (SUM_W > NEED_W) ? SUM_W : NEED_W;
  localparam logic [BIN_W:0]   BINS     = (BIN_W+1)'(PRICE_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(PRICE_BINS - 1);

  logic              busy_q;
  logic [BIN_W:0]    iss_q;
  logic              vld_q;
  logic [BIN_W-1:0]  here_q;
  logic [2:0]        seg_q;
  logic [ACC_W-1:0]  sum_q;
  logic [ACC_W-1:0]  need_q;
  logic [ACC_W-1:0]  acc;
  logic              hit;
  logic [PRICE_W:0]  lvl_sum;
  logic [PCT_W-1:0]  pct_next;

  assign raddr_o  = iss_q[BIN_W-1:0];
  assign acc      = sum_q + ACC_W'(rdata_i) * ACC_W'(7'd100);
  assign hit      = busy_q && vld_q && (acc >= need_q);
  assign lvl_sum  = {1'b0, base_i} + (PRICE_W+1)'(here_q);
  assign pct_next = (seg_q < 3'd4) ? pct_i[seg_q + 3'd1] : pct_i[0];

  always_comb begin
    lvl_wr_o.we    = hit;
    lvl_wr_o.idx   = seg_q;
    lvl_wr_o.value = lvl_sum[PRICE_W] ? {PRICE_W{1'b1}} : lvl_sum[PRICE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      vld_q       <= 1'b0;
      iss_q       <= '0;
      stat_o.done <= 1'b0;
      stat_o.err  <= 1'b0;
    end else begin
      stat_o.done <= 1'b0;
      if (start_i) begin
        busy_q     <= 1'b1;
        vld_q      <= 1'b0;
        iss_q      <= '0;
        stat_o.err <= 1'b0;
      end else if (busy_q) begin
        vld_q <= (iss_q < BINS);
        if (iss_q < BINS) begin
          iss_q <= iss_q + 1'b1;
        end
        if (vld_q) begin
          if (hit && seg_q == 3'd4) begin
            busy_q      <= 1'b0;
            stat_o.done <= 1'b1;
          end else if (here_q == LAST_BIN) begin
            // segment still open at the last bin: no level
            busy_q      <= 1'b0;
            stat_o.done <= 1'b1;
            stat_o.err  <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      seg_q  <= '0;
      sum_q  <= '0;
      need_q <= ACC_W'(pct_i[0]) * ACC_W'(len_i);
    end else if (busy_q) begin
      if (iss_q < BINS) begin
        here_q <= iss_q[BIN_W-1:0];
      end
      if (hit) begin
        seg_q  <= seg_q + 3'd1;
        sum_q  <= '0;
        need_q <= ACC_W'(pct_next) * ACC_W'(len_i);
      end else if (vld_q) begin
        sum_q <= acc;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sliding_window_quantile_zoner.sv
// ----------------------------------------------------------------------------
// sliding_window_quantile_zoner
// Sliding window of minute mid prices with histogram quantile zone levels.
// ----------------------------------------------------------------------------
// Query or ignored tick: straight to the response. Tick while filling: ring write,
// count increment, response. Tick on a full window: evict read and write, increment
// read and write, then the histogram scan, one bin read from the count RAM per cycle.
// One item at a time; the next item is taken while a result waits in m_axis.
// After reset a clearing pass zeroes every bin of the histogram RAM;
// no item is taken during it, configuration writes are.
`default_nettype none

module sliding_window_quantile_zoner #(
  parameter int unsigned HISTORY_MAX = 1024,
  parameter int unsigned PRICE_BINS  = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [swqz_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [swqz_pkg::PRICE_W-1:0]    cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [47:0]                     s_axis_tdata,  // ask, bid, minute_of_hour
  input  wire logic                            s_axis_tuser,  // func
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [7:0]                      m_axis_tdata,  // zone_code, level_error
  output logic                                 m_axis_tuser   // tick_taken
);
  import swqz_pkg::*;

  localparam int unsigned HW    = $clog2(HISTORY_MAX);
  localparam int unsigned BIN_W = $clog2(PRICE_BINS);
  localparam int unsigned LEN_W = (HW + 1 > WL_W) ? HW + 1 : WL_W;
  localparam logic [LEN_W-1:0] HMAX     = LEN_W'(HISTORY_MAX);
  localparam logic [HW:0]      HMAX_F   = (HW+1)'(HISTORY_MAX);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(PRICE_BINS - 1);

  // configuration
  logic [WL_W-1:0]    wlen_q;
  logic [PRICE_W-1:0] base_q;
  logic [PCT_W-1:0]   pct_q [NUM_LVL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= WL_W'(60);
      base_q   <= '0;
      pct_q[0] <= PCT_W'(1);
      pct_q[1] <= PCT_W'(4);
      pct_q[2] <= PCT_W'(20);
      pct_q[3] <= PCT_W'(50);
      pct_q[4] <= PCT_W'(20);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_LENGTH: wlen_q   <= cfg_data_i[WL_W-1:0];
        CFG_PRICE_BASE:    base_q   <= cfg_data_i;
        CFG_FLOOR_PCT:     pct_q[0] <= cfg_data_i[PCT_W-1:0];
        CFG_LOW_PCT:       pct_q[1] <= cfg_data_i[PCT_W-1:0];
        CFG_MID_PCT:       pct_q[2] <= cfg_data_i[PCT_W-1:0];
        CFG_HIGH_PCT:      pct_q[3] <= cfg_data_i[PCT_W-1:0];
        CFG_CEILING_PCT:   pct_q[4] <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective window length, clamped to 1..HISTORY_MAX
  logic [LEN_W-1:0] wl_ext, len;
  assign wl_ext = LEN_W'(wlen_q);
  always_comb begin
    if (wl_ext == '0)      len = LEN_W'(1);
    else if (wl_ext > HMAX) len = HMAX;
    else                   len = wl_ext;
  end

  // control state
  state_e             state_q, state_d;
  logic [BIN_W-1:0]   clr_q;
  logic [HW-1:0]      head_q;
  logic [HW:0]        fill_q;
  logic [MIN_W-1:0]   last_min_q;
  logic [BIN_W-1:0]   bin_q;
  logic [BIN_W-1:0]   old_q;
  logic [PRICE_W-1:0] lvl_q [NUM_LVL];
  logic [ZONE_W-1:0]  res_zone_q;
  logic               res_tick_q;
  logic               res_err_q;
  logic               full;

  assign full = (LEN_W'(fill_q) >= len);

  // input decode
  logic               in_fire;
  logic [PRICE_W-1:0] ask, bid, price;
  logic [PRICE_W:0]   mid_sum, diff;
  logic [MIN_W-1:0]   minute;
  logic [BIN_W-1:0]   bin_in;
  logic [ZONE_W-1:0]  zone;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign ask     = s_axis_tdata[19:0];
  assign bid     = s_axis_tdata[39:20];
  assign minute  = s_axis_tdata[45:40];
  assign mid_sum = {1'b0, ask} + {1'b0, bid};
  assign price   = mid_sum[PRICE_W:1];
  assign diff    = {1'b0, price} - {1'b0, base_q};

  always_comb begin
    if (price < base_q)                              bin_in = '0;
    else if (diff > (PRICE_W+1)'(PRICE_BINS - 1))    bin_in = LAST_BIN;
    else                                             bin_in = diff[BIN_W-1:0];
  end

  always_comb begin
    if (!full)                 zone = ZONE_UNKNOWN;
    else if (price < lvl_q[0]) zone = ZONE_EXTREME;
    else if (price < lvl_q[1]) zone = ZONE_VERY_LOW;
    else if (price < lvl_q[2]) zone = ZONE_LOW;
    else if (price < lvl_q[3]) zone = ZONE_NORMAL;
    else if (price < lvl_q[4]) zone = ZONE_HIGH;
    else                       zone = ZONE_EXTREME;
  end

  // ring addresses
  logic [HW:0]   tail_fill_sum, tail_full_sum;
  logic [HW-1:0] tail_fill, tail_full, head_nxt;

  assign head_nxt      = (head_q == HW'(HISTORY_MAX - 1)) ? '0 : head_q + 1'b1;
  assign tail_fill_sum = (HW+1)'(head_q) + fill_q;
  assign tail_fill     = (tail_fill_sum >= HMAX_F) ? HW'(tail_fill_sum - HMAX_F)
                                                   : tail_fill_sum[HW-1:0];
  assign tail_full_sum = (HW+1)'(head_nxt) + fill_q - 1'b1;
  assign tail_full     = (tail_full_sum >= HMAX_F) ? HW'(tail_full_sum - HMAX_F)
                                                   : tail_full_sum[HW-1:0];

  // memories
  logic             ring_we;
  logic [HW-1:0]    ring_waddr;
  logic [BIN_W-1:0] ring_rdata;
  logic             cnt_we;
  logic [BIN_W-1:0] cnt_waddr, cnt_raddr, scan_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata, cnt_inc, cnt_dec;
  lvl_wr_t          lvl_wr;
  scan_stat_t       scan_stat;
  logic             scan_start;

  assign cnt_inc = (cnt_rdata < CNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
  assign cnt_dec = (cnt_rdata != '0) ? cnt_rdata - 1'b1 : cnt_rdata;

  swqz_ram #(.WIDTH(BIN_W), .DEPTH(HISTORY_MAX)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (bin_q),
    .raddr_i (head_q),
    .rdata_o (ring_rdata)
  );

  swqz_ram #(.WIDTH(CNT_W), .DEPTH(PRICE_BINS)) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  swqz_scan #(.PRICE_BINS(PRICE_BINS), .LEN_W(LEN_W)) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .len_i    (len),
    .pct_i    (pct_q),
    .base_i   (base_q),
    .raddr_o  (scan_raddr),
    .rdata_i  (cnt_rdata),
    .lvl_wr_o (lvl_wr),
    .stat_o   (scan_stat)
  );

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = (state_q == ST_IDLE);
    ring_we       = 1'b0;
    ring_waddr    = tail_fill;
    cnt_we        = 1'b0;
    cnt_waddr     = bin_q;
    cnt_wdata     = cnt_inc;
    cnt_raddr     = bin_q;
    scan_start    = 1'b0;
    case (state_q)
      ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        cnt_wdata = '0;
        if (clr_q == LAST_BIN) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser || minute == last_min_q) state_d = ST_RESP;
          else if (!full)                           state_d = ST_FILL;
          else                                      state_d = ST_EVICT_RD;
        end
      end
      ST_FILL: begin
        ring_we = 1'b1;
        state_d = ST_FILL_WR;
      end
      ST_FILL_WR: begin
        cnt_we  = 1'b1;
        state_d = ST_RESP;
      end
      ST_EVICT_RD: begin
        cnt_raddr = ring_rdata;
        state_d   = ST_EVICT_WR;
      end
      ST_EVICT_WR: begin
        cnt_we     = 1'b1;
        cnt_waddr  = old_q;
        cnt_wdata  = cnt_dec;
        ring_we    = 1'b1;
        ring_waddr = tail_full;
        state_d    = ST_INC_RD;
      end
      ST_INC_RD: state_d = ST_INC_WR;
      ST_INC_WR: begin
        cnt_we     = 1'b1;
        scan_start = 1'b1;
        state_d    = ST_SCAN;
      end
      ST_SCAN: begin
        cnt_raddr = scan_raddr;
        if (scan_stat.done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!m_axis_tvalid || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q         <= '0;
      head_q        <= '0;
      fill_q        <= '0;
      last_min_q    <= '0;
      m_axis_tvalid <= 1'b0;
      for (int i = 0; i < NUM_LVL; i++) lvl_q[i] <= '0;
    end else begin
      if (state_q == ST_CLR) clr_q <= clr_q + 1'b1;
      if (in_fire && !s_axis_tuser) last_min_q <= minute;
      if (state_q == ST_FILL) fill_q <= fill_q + 1'b1;
      if (state_q == ST_EVICT_WR) head_q <= head_nxt;
      if (lvl_wr.we) lvl_q[lvl_wr.idx] <= lvl_wr.value;
      if (state_q == ST_RESP && !m_axis_tvalid) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= (state_q == ST_RESP);
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bin_q      <= bin_in;
      res_zone_q <= s_axis_tuser ? zone : ZONE_UNKNOWN;
      res_tick_q <= !s_axis_tuser && (minute != last_min_q);
      res_err_q  <= 1'b0;
    end
    if (state_q == ST_EVICT_RD) old_q <= ring_rdata;
    if (state_q == ST_SCAN && scan_stat.done) res_err_q <= scan_stat.err;
    if (state_q == ST_RESP && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {4'b0, res_err_q, res_zone_q};
      m_axis_tuser <= res_tick_q;
    end
  end

  // hold input off during the clearing pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("item taken during histogram clear");

  // the window never holds more than HISTORY_MAX entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= HMAX_F)
    else $error("fill count beyond history depth");

  // a scan starts only for a tick on a full window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_start |-> full && res_tick_q)
    else $error("scan started without a full window");

  // fill count moves only on a tick into a window that is filling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ($past(state_q) == ST_FILL))
    else $error("fill count changed outside a fill");

endmodule

`default_nettype wire
